### rtl/evcp_pkg.sv
// Shared types, constants and helpers for the edge view / clip / projection pipeline.
package evcp_pkg;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
  } vec_t;

  // Edge after clipping, ready for projection
  typedef struct packed {
    logic vis;
    vec_t a;
    vec_t b;
  } edge_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_CAMERA_X     = 3'd0;
  localparam logic [2:0] CFG_CAMERA_Y     = 3'd1;
  localparam logic [2:0] CFG_CAMERA_Z     = 3'd2;
  localparam logic [2:0] CFG_RIGHT_AXIS   = 3'd3;
  localparam logic [2:0] CFG_UP_AXIS      = 3'd4;
  localparam logic [2:0] CFG_FORWARD_AXIS = 3'd5;

  // Near plane 0.05 in Q16.16
  localparam q16_t NEAR_Q16 = 32'sd3277;
  // Clip factor fraction bits
  localparam int T_FRAC = 28;
  // Focal length 8 times Q16.16 scale is a left shift by 19
  localparam int FOCAL_SHIFT = 19;
  // Quotient bits of the projection divide
  localparam int PROJ_QW = 32;

  localparam q16_t Q16_MAX = 32'sh7fff_ffff;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  // Saturate a 37-bit signed value to 32 bits
  function automatic q16_t sat37(input logic signed [36:0] v);
    q16_t r;
    if (v > 37'sh0_7fff_ffff) begin
      r = Q16_MAX;
    end else if (v < -37'sh0_8000_0000) begin
      r = Q16_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/evcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband tag.
module evcp_div import evcp_pkg::*; #(
  parameter int NW = 59,
  parameter int DW = 33,
  parameter int QW = 28,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [TW-1:0] out_tag
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [TW-1:0] tg  [QW+1];
  logic          vld [QW+1];

  assign rem[0] = dividend;
  assign dv[0]  = divisor;
  assign q[0]   = '0;
  assign tg[0]  = tag;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int BIT = QW - 1 - s;
    logic [W-1:0] rem_ext;
    logic [W-1:0] trial;
    logic         ge;

    // trial subtract of divisor scaled to this quotient bit
    always_comb begin
      rem_ext = W'(rem[s]);
      trial   = W'(dv[s]) << BIT;
      ge      = rem_ext >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1] <= ge ? NW'(rem_ext - trial) : rem[s];
      dv[s+1]  <= dv[s];
      q[s+1]   <= q[s] | (QW'(ge) << BIT);
      tg[s+1]  <= tg[s];
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = q[QW];
  assign out_tag   = tg[QW];

endmodule

### rtl/evcp_view.sv
// View transform: camera offset and dot products with the three axes, two stages.
module evcp_view import evcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  vec_t        pa,
  input  vec_t        pb,
  input  q16_t        camera_x,
  input  q16_t        camera_y,
  input  q16_t        camera_z,
  input  logic [47:0] right_axis,
  input  logic [47:0] up_axis,
  input  logic [47:0] forward_axis,
  output logic        out_valid,
  output vec_t        va,
  output vec_t        vb
);

  q16_t               pt   [2][3];
  q16_t               cam  [3];
  logic [47:0]        ax   [3];
  logic signed [32:0] d    [2][3];
  logic signed [48:0] prod_next [2][3][3];
  logic signed [48:0] prod [2][3][3];
  logic               vld1;
  logic signed [50:0] sum  [2][3];
  q16_t               vr   [2][3];

  assign pt[0][0] = pa.x;
  assign pt[0][1] = pa.y;
  assign pt[0][2] = pa.z;
  assign pt[1][0] = pb.x;
  assign pt[1][1] = pb.y;
  assign pt[1][2] = pb.z;
  assign cam[0] = camera_x;
  assign cam[1] = camera_y;
  assign cam[2] = camera_z;
  assign ax[0] = right_axis;
  assign ax[1] = up_axis;
  assign ax[2] = forward_axis;

  // stage 1: offsets and the nine products per end
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int c = 0; c < 3; c++) begin
        d[e][c] = 33'(pt[e][c]) - 33'(cam[c]);
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_next[e][r][c] = d[e][c] * $signed(ax[r][16*c +: 16]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1      <= in_valid;
      out_valid <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

  // stage 2: sum, floor shift by 14, saturate
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int r = 0; r < 3; r++) begin
        sum[e][r] = 51'(prod[e][r][0]) + 51'(prod[e][r][1]) + 51'(prod[e][r][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 2; e++) begin
      for (int r = 0; r < 3; r++) begin
        vr[e][r] <= sat37(sum[e][r][50:14]);
      end
    end
  end

  assign va = '{x: vr[0][0], y: vr[0][1], z: vr[0][2]};
  assign vb = '{x: vr[1][0], y: vr[1][1], z: vr[1][2]};

endmodule

### rtl/evcp_clip.sv
// Near-plane clip: classify ends, divide for the clip factor, interpolate the moved end.
module evcp_clip import evcp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  vec_t  va,
  input  vec_t  vb,
  output logic  out_valid,
  output edge_t out_edge
);

  typedef struct packed {
    logic vis;
    logic clip_a;
    logic clip_b;
    vec_t a;
    vec_t b;
  } clip_tag_t;

  localparam int NUM_W = 31;
  localparam int DEN_W = 33;
  localparam int TAG_W = $bits(clip_tag_t);

  logic               a_in;
  logic               b_in;
  vec_t               k_sel;
  vec_t               m_sel;
  logic               c0_valid;
  logic [NUM_W-1:0]   c0_num;
  logic [DEN_W-1:0]   c0_den;
  clip_tag_t          c0_tag;
  logic               dv_valid;
  logic [T_FRAC-1:0]  t;
  logic [TAG_W-1:0]   dv_tag_raw;
  clip_tag_t          dv_tag;
  vec_t               k_d;
  vec_t               m_d;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic               m_valid;
  logic signed [61:0] px;
  logic signed [61:0] py;
  clip_tag_t          m_tag;
  vec_t               k_m;
  q16_t               nx;
  q16_t               ny;
  vec_t               moved;

  // classify ends and pick the end that stays (k) and the one that moves (m)
  always_comb begin
    a_in  = va.z >= NEAR_Q16;
    b_in  = vb.z >= NEAR_Q16;
    k_sel = (!a_in) ? vb : va;
    m_sel = (!a_in) ? va : vb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c0_valid <= 1'b0;
    end else begin
      c0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    c0_num <= NUM_W'(k_sel.z - NEAR_Q16);
    c0_den <= DEN_W'(33'(k_sel.z) - 33'(m_sel.z));
    c0_tag <= '{vis: a_in | b_in, clip_a: !a_in & b_in, clip_b: a_in & !b_in,
                a: va, b: vb};
  end

  // clip factor t = num * 2^28 / den, below one since num < den
  evcp_div #(
    .NW(NUM_W + T_FRAC),
    .DW(DEN_W),
    .QW(T_FRAC),
    .TW(TAG_W)
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c0_valid),
    .dividend  ({c0_num, {T_FRAC{1'b0}}}),
    .divisor   (c0_den),
    .tag       (c0_tag),
    .out_valid (dv_valid),
    .quotient  (t),
    .out_tag   (dv_tag_raw)
  );

  // scale the span from k to m by t
  always_comb begin
    dv_tag = clip_tag_t'(dv_tag_raw);
    k_d    = dv_tag.clip_a ? dv_tag.b : dv_tag.a;
    m_d    = dv_tag.clip_a ? dv_tag.a : dv_tag.b;
    dx     = 33'(m_d.x) - 33'(k_d.x);
    dy     = 33'(m_d.y) - 33'(k_d.y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      m_valid   <= dv_valid;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    px    <= dx * $signed({1'b0, t});
    py    <= dy * $signed({1'b0, t});
    m_tag <= dv_tag;
  end

  // crossing point: k plus floor of the scaled span, z on the plane
  always_comb begin
    k_m   = m_tag.clip_a ? m_tag.b : m_tag.a;
    nx    = k_m.x + q16_t'(px[61:T_FRAC]);
    ny    = k_m.y + q16_t'(py[61:T_FRAC]);
    moved = '{x: nx, y: ny, z: NEAR_Q16};
  end

  always_ff @(posedge clk) begin
    out_edge.vis <= m_tag.vis;
    out_edge.a   <= m_tag.clip_a ? moved : m_tag.a;
    out_edge.b   <= m_tag.clip_b ? moved : m_tag.b;
  end

endmodule

### rtl/evcp_proj.sv
// Perspective projection: four pipelined divides of coordinate * 8 by depth, saturated.
module evcp_proj import evcp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  edge_t in_edge,
  output logic  out_valid,
  output logic  visible,
  output q16_t  screen_start_x,
  output q16_t  screen_start_y,
  output q16_t  screen_end_x,
  output q16_t  screen_end_y
);

  localparam int DIV_NW = 32 + FOCAL_SHIFT;
  localparam int TAG_W  = 3;

  q16_t              c_in   [4];
  q16_t              z_in   [4];
  logic [31:0]       mag    [4];
  logic              p0_valid;
  logic [DIV_NW-1:0] p0_dvd [4];
  logic [31:0]       p0_dvs [4];
  logic [TAG_W-1:0]  p0_tag [4];
  logic              dv_valid [4];
  logic [PROJ_QW-1:0] q     [4];
  logic [TAG_W-1:0]  dv_tag [4];
  q16_t              res    [4];

  assign c_in[0] = in_edge.a.x;
  assign c_in[1] = in_edge.a.y;
  assign c_in[2] = in_edge.b.x;
  assign c_in[3] = in_edge.b.y;
  assign z_in[0] = in_edge.a.z;
  assign z_in[1] = in_edge.a.z;
  assign z_in[2] = in_edge.b.z;
  assign z_in[3] = in_edge.b.z;

  // magnitude, sign and overflow check (quotient would reach 2^32)
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag[l] = c_in[l][31] ? 32'(-c_in[l]) : 32'(c_in[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      p0_dvd[l] <= {mag[l], {FOCAL_SHIFT{1'b0}}};
      p0_dvs[l] <= z_in[l];
      p0_tag[l] <= {in_edge.vis, c_in[l][31],
                    {13'd0, mag[l]} >= {z_in[l], 13'd0}};
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    evcp_div #(
      .NW(DIV_NW),
      .DW(32),
      .QW(PROJ_QW),
      .TW(TAG_W)
    ) u_pdiv (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (p0_valid),
      .dividend  (p0_dvd[l]),
      .divisor   (p0_dvs[l]),
      .tag       (p0_tag[l]),
      .out_valid (dv_valid[l]),
      .quotient  (q[l]),
      .out_tag   (dv_tag[l])
    );
  end

  // apply sign, saturate, zero when the edge is hidden
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (!dv_tag[l][2]) begin
        res[l] = '0;
      end else if (dv_tag[l][1]) begin
        res[l] = (dv_tag[l][0] || q[l] > 32'h8000_0000) ? Q16_MIN : q16_t'(-q[l]);
      end else begin
        res[l] = (dv_tag[l][0] || q[l][31]) ? Q16_MAX : q16_t'(q[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid[0] & dv_valid[1] & dv_valid[2] & dv_valid[3];
    end
  end

  always_ff @(posedge clk) begin
    visible        <= dv_tag[0][2];
    screen_start_x <= res[0];
    screen_start_y <= res[1];
    screen_end_x   <= res[2];
    screen_end_y   <= res[3];
  end

endmodule

### rtl/edge_view_clip_project.sv
// Top level: configuration registers and the view, clip and projection pipeline.
//
// Takes one edge per clock: start is accepted whenever it is high, busy stays low. Each
// item gives exactly one result, shown on done for one cycle, after the view transform,
// clipping (the 28-stage clip-factor divider plus setup and interpolation registers) and
// projection (four 32-stage dividers plus setup and saturation registers). The receiver
// cannot stall, so results appear in input order. Write configuration only with the
// pipeline empty.
module edge_view_clip_project import evcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  q16_t        start_x,
  input  q16_t        start_y,
  input  q16_t        start_z,
  input  q16_t        end_x,
  input  q16_t        end_y,
  input  q16_t        end_z,
  output logic        done,
  output logic        visible,
  output q16_t        screen_start_x,
  output q16_t        screen_start_y,
  output q16_t        screen_end_x,
  output q16_t        screen_end_y
);

  localparam int PIPE_DEPTH = 2 + (3 + T_FRAC) + (2 + PROJ_QW);

  q16_t        camera_x;
  q16_t        camera_y;
  q16_t        camera_z;
  logic [47:0] right_axis;
  logic [47:0] up_axis;
  logic [47:0] forward_axis;
  logic        view_valid;
  vec_t        view_a;
  vec_t        view_b;
  logic        clip_valid;
  edge_t       clip_edge;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x     <= '0;
      camera_y     <= '0;
      camera_z     <= '0;
      right_axis   <= '0;
      up_axis      <= '0;
      forward_axis <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAMERA_X:     camera_x     <= cfg_data[31:0];
        CFG_CAMERA_Y:     camera_y     <= cfg_data[31:0];
        CFG_CAMERA_Z:     camera_z     <= cfg_data[31:0];
        CFG_RIGHT_AXIS:   right_axis   <= cfg_data;
        CFG_UP_AXIS:      up_axis      <= cfg_data;
        CFG_FORWARD_AXIS: forward_axis <= cfg_data;
        default: ;
      endcase
    end
  end

  evcp_view u_view (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start),
    .pa           ('{x: start_x, y: start_y, z: start_z}),
    .pb           ('{x: end_x, y: end_y, z: end_z}),
    .camera_x     (camera_x),
    .camera_y     (camera_y),
    .camera_z     (camera_z),
    .right_axis   (right_axis),
    .up_axis      (up_axis),
    .forward_axis (forward_axis),
    .out_valid    (view_valid),
    .va           (view_a),
    .vb           (view_b)
  );

  evcp_clip u_clip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (view_valid),
    .va        (view_a),
    .vb        (view_b),
    .out_valid (clip_valid),
    .out_edge  (clip_edge)
  );

  evcp_proj u_proj (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (clip_valid),
    .in_edge        (clip_edge),
    .out_valid      (done),
    .visible        (visible),
    .screen_start_x (screen_start_x),
    .screen_start_y (screen_start_y),
    .screen_end_x   (screen_end_x),
    .screen_end_y   (screen_end_y)
  );

  // every item comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##PIPE_DEPTH done)
    else $error("item did not complete at pipeline depth");

  // no result without an item that entered at the right time
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_DEPTH))
    else $error("result without a matching item");

  // hidden edge gives zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    done && !visible |-> screen_start_x == 0 && screen_start_y == 0 &&
                         screen_end_x == 0 && screen_end_y == 0)
    else $error("hidden edge with nonzero coordinates");

endmodule

### tb/tb_edge_view_clip_project.sv
// Testbench for the edge view transform, near-plane clip and projection block.
module tb_edge_view_clip_project;
  import evcp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  // Index past the register list, the block ignores it
  localparam logic [2:0] CFG_SPARE = 3'd6;
  localparam logic [15:0] AXIS_ONE = 16'h4000;

  typedef struct {
    logic vis;
    q16_t sx;
    q16_t sy;
    q16_t ex;
    q16_t ey;
  } screen_edge_t;

  // Keeps the camera setup, predicts each edge and checks results in order
  class edge_scoreboard;
    q16_t cam_x, cam_y, cam_z;
    logic [47:0] right_ax, up_ax, fwd_ax;
    screen_edge_t pending[$];
    int errors;

    function new();
      cam_x = '0; cam_y = '0; cam_z = '0;
      right_ax = '0; up_ax = '0; fwd_ax = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        CFG_CAMERA_X:     cam_x = val[31:0];
        CFG_CAMERA_Y:     cam_y = val[31:0];
        CFG_CAMERA_Z:     cam_z = val[31:0];
        CFG_RIGHT_AXIS:   right_ax = val;
        CFG_UP_AXIS:      up_ax = val;
        CFG_FORWARD_AXIS: fwd_ax = val;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Dot product with a Q2.14 axis, floored back to Q16.16
    function longint axis_dot(longint dx, longint dy, longint dz, logic [47:0] ax);
      longint s;
      s = dx * longint'($signed(ax[15:0])) + dy * longint'($signed(ax[31:16]))
        + dz * longint'($signed(ax[47:32]));
      return clamp32(s >>> 14);
    endfunction

    // Move end m onto the near plane along the edge toward the kept end k
    function void pull_to_near(inout longint mx, inout longint my, inout longint mz,
                               input longint kx, input longint ky, input longint kz);
      longint num, den, t;
      num = kz - longint'(NEAR_Q16);
      den = kz - mz;
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      t = (num <<< T_FRAC) / den;
      mx = kx + (((mx - kx) * t) >>> T_FRAC);
      my = ky + (((my - ky) * t) >>> T_FRAC);
      mz = longint'(NEAR_Q16);
    endfunction

    function q16_t persp(longint c, longint z);
      longint r;
      r = clamp32((c <<< FOCAL_SHIFT) / z);
      return r[31:0];
    endfunction

    function void note_edge(q16_t sx, q16_t sy, q16_t sz, q16_t ex, q16_t ey, q16_t ez);
      longint ax, ay, az, bx, by, bz, dx, dy, dz;
      logic a_in, b_in;
      screen_edge_t r;
      dx = longint'(sx) - longint'(cam_x);
      dy = longint'(sy) - longint'(cam_y);
      dz = longint'(sz) - longint'(cam_z);
      ax = axis_dot(dx, dy, dz, right_ax);
      ay = axis_dot(dx, dy, dz, up_ax);
      az = axis_dot(dx, dy, dz, fwd_ax);
      dx = longint'(ex) - longint'(cam_x);
      dy = longint'(ey) - longint'(cam_y);
      dz = longint'(ez) - longint'(cam_z);
      bx = axis_dot(dx, dy, dz, right_ax);
      by = axis_dot(dx, dy, dz, up_ax);
      bz = axis_dot(dx, dy, dz, fwd_ax);
      a_in = az >= longint'(NEAR_Q16);
      b_in = bz >= longint'(NEAR_Q16);
      if (!a_in && !b_in) begin
        r = '{1'b0, '0, '0, '0, '0};
      end else begin
        if (!a_in) pull_to_near(ax, ay, az, bx, by, bz);
        else if (!b_in) pull_to_near(bx, by, bz, ax, ay, az);
        r.vis = 1'b1;
        r.sx = persp(ax, az);
        r.sy = persp(ay, az);
        r.ex = persp(bx, bz);
        r.ey = persp(by, bz);
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(screen_edge_t got);
      screen_edge_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: vis=%0d", got.vis);
        return;
      end
      exp_r = pending.pop_front();
      if (got.vis !== exp_r.vis || got.sx !== exp_r.sx || got.sy !== exp_r.sy ||
          got.ex !== exp_r.ex || got.ey !== exp_r.ey) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp vis=%0d %h %h %h %h, got vis=%0d %h %h %h %h",
                   exp_r.vis, exp_r.sx, exp_r.sy, exp_r.ex, exp_r.ey,
                   got.vis, got.sx, got.sy, got.ex, got.ey);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  q16_t start_x = '0, start_y = '0, start_z = '0;
  q16_t end_x = '0, end_y = '0, end_z = '0;
  logic done, visible;
  q16_t screen_start_x, screen_start_y, screen_end_x, screen_end_y;

  edge_scoreboard sb = new();
  int idle_pct = 0;
  int cycles = 0;

  edge_view_clip_project u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z),
    .done(done), .visible(visible),
    .screen_start_x(screen_start_x), .screen_start_y(screen_start_y),
    .screen_end_x(screen_end_x), .screen_end_y(screen_end_y)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Accepted items and results, sampled at the edge
  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_edge(start_x, start_y, start_z, end_x, end_y, end_z);
    if (!rst && done)
      sb.check_result('{visible, screen_start_x, screen_start_y, screen_end_x, screen_end_y});
  end

  function automatic logic [47:0] pack_axis(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  // Mostly small coordinates so edges straddle the near plane; some full range
  function automatic q16_t rnd_coord();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      2:       return q16_t'($signed($urandom_range(32'h0200_0000))) - 32'sh0100_0000;
      default: return q16_t'($signed($urandom_range(32'h0020_0000))) - 32'sh0010_0000;
    endcase
  endfunction

  // One write, then the write enable is dropped again on the port
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Let the pipeline empty out completely
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_edge(q16_t sx, q16_t sy, q16_t sz, q16_t ex, q16_t ey, q16_t ez);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    start_x <= sx; start_y <= sy; start_z <= sz;
    end_x <= ex; end_y <= ey; end_z <= ez;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && $urandom_range(1)) begin
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_edge(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setup: zero axes put every edge behind the plane
    idle_pct = 37;
    send_edge(32'sh0001_0000, 0, 32'sh0010_0000, 0, 0, 32'sh7fff_ffff);
    send_random(10);
    drain();

    // Identity basis, camera at origin: directed clipping cases
    write_reg(CFG_CAMERA_X, 48'd0);
    write_reg(CFG_CAMERA_Y, 48'd0);
    write_reg(CFG_CAMERA_Z, 48'd0);
    write_reg(CFG_RIGHT_AXIS, pack_axis(AXIS_ONE, 16'h0, 16'h0));
    write_reg(CFG_UP_AXIS, pack_axis(16'h0, AXIS_ONE, 16'h0));
    write_reg(CFG_FORWARD_AXIS, pack_axis(16'h0, 16'h0, AXIS_ONE));
    write_reg(CFG_SPARE, 48'hffff_ffff_ffff);
    // both in front
    send_edge(32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000,
              -32'sh0003_0000, 32'sh0000_8000, 32'sh0010_0000);
    // both behind
    send_edge(1, 2, -32'sh0001_0000, 3, 4, 32'sd3276);
    // start behind, then end behind, then each end exactly on the plane
    send_edge(32'sh0001_0000, 32'sh0001_0000, -32'sh0002_0000,
              -32'sh0001_0000, 32'sh0002_0000, 32'sh0002_0000);
    send_edge(32'sh0005_0000, -32'sh0001_0000, 32'sh0003_0000,
              32'sh0001_0000, 32'sh0004_0000, -32'sh0006_0000);
    send_edge(32'sh0001_0000, 32'sh0001_0000, 32'sd3277, 0, 0, 32'sd3276);
    send_edge(0, 0, 32'sd3276, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd3277);
    // extreme coordinates, saturated projection
    send_edge(32'sh7fff_ffff, 32'sh8000_0000, 32'sd3277,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_edge(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_edge(-1, -1, -1, 0, 0, 0);
    send_random(80);
    drain();

    // Extreme camera and extreme axis components force view saturation
    write_reg(CFG_CAMERA_X, 48'h0000_8000_0000);
    write_reg(CFG_CAMERA_Y, 48'h0000_7fff_ffff);
    write_reg(CFG_CAMERA_Z, 48'h0000_8000_0000);
    write_reg(CFG_RIGHT_AXIS, pack_axis(16'h8000, 16'h7fff, 16'h8000));
    write_reg(CFG_UP_AXIS, pack_axis(16'h7fff, 16'h8000, 16'h7fff));
    write_reg(CFG_FORWARD_AXIS, pack_axis(16'h7fff, 16'h7fff, 16'h7fff));
    send_edge(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send_random(80);
    drain();

    // Random setups: mostly small camera offsets, random right and up axes, unit forward on odd ones
    for (int s = 0; s < 5; s++) begin
      idle_pct = (s < 2) ? 84 : 0;
      write_reg(CFG_CAMERA_X, {16'h0, rnd_coord()});
      write_reg(CFG_CAMERA_Y, {16'h0, rnd_coord()});
      write_reg(CFG_CAMERA_Z, {16'h0, rnd_coord()});
      write_reg(CFG_RIGHT_AXIS, 48'({$urandom(), $urandom()}));
      write_reg(CFG_UP_AXIS, 48'({$urandom(), $urandom()}));
      write_reg(CFG_FORWARD_AXIS, (s % 2) ? pack_axis(16'h0, 16'h0, AXIS_ONE)
                                          : 48'({$urandom(), $urandom()}));
      write_reg(CFG_SPARE + 3'(s % 2), 48'({$urandom(), $urandom()}));
      send_random(75);
      drain();
    end

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
